/* hdl/assert_macros.svh */
// Assertion macros shared by the percent codec modules.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold in the same cycle as ante
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

// cond must never be seen out of reset
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("%m: assertion failed");

`endif

/* hdl/ucodec_pkg.sv */
// Types, constants and helper functions of the URL percent codec.
// No dependencies; imported by every file of the block but assert_macros.svh.
package ucodec_pkg;

  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DECODE_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SET_0       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SET_1       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SET_2       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SET_3       = 3'd4;

  localparam logic [CHAR_W-1:0] PERCENT_CHAR = 8'h25; // '%'
  localparam logic [CHAR_W-1:0] DIGIT_BASE   = 8'h30; // '0'
  localparam logic [CHAR_W-1:0] DIGIT_LAST   = 8'h39; // '9'
  localparam logic [CHAR_W-1:0] ALPHA_BASE   = 8'h37; // 'A' - 10

  // decoder escape tracking
  typedef enum logic [2:0] {
    ESC_IDLE = 3'b001,
    ESC_PCT  = 3'b010,
    ESC_DIG  = 3'b100
  } esc_state_e;

  // output sequencer for one queued operation
  typedef enum logic [2:0] {
    PH_FIRST = 3'b001,
    PH_HI    = 3'b010,
    PH_LO    = 3'b100
  } out_phase_e;

  // one classified operation passed from front to back
  typedef struct packed {
    logic              esc;  // expand to '%', high digit, low digit
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              cut;
  } op_t;

  // uppercase hex digit of a nibble
  function automatic logic [CHAR_W-1:0] hex_digit(input logic [3:0] v);
    logic [CHAR_W-1:0] w;
    w = {4'b0000, v};
    return (v >= 4'd10) ? (w + ALPHA_BASE) : (w + DIGIT_BASE);
  endfunction

  // nibble value of an escape digit; any byte is accepted and wraps
  function automatic logic [3:0] nibble_of(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] base;
    logic [CHAR_W-1:0] diff;
    base = (c >= DIGIT_BASE && c <= DIGIT_LAST) ? DIGIT_BASE : ALPHA_BASE;
    diff = c - base;
    return diff[3:0];
  endfunction

endpackage

/* hdl/ucodec_if.sv */
// Handshake channel interfaces of the percent codec: input, output, config.
// Depends on ucodec_pkg for field widths.
interface ucodec_in_if import ucodec_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] in_char;
  logic              in_end;
  modport source (output valid, in_char, in_end, input ready);
  modport sink   (input valid, in_char, in_end, output ready);
endinterface

interface ucodec_out_if import ucodec_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              out_end;
  logic              cut_escape;
  modport source (output valid, out_char, out_end, cut_escape, input ready);
  modport sink   (input valid, out_char, out_end, cut_escape, output ready);
endinterface

interface ucodec_cfg_if import ucodec_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/ucodec_front.sv */
// Front end: config registers, input acceptance, classification and decode.
// Depends on ucodec_pkg and assert_macros.svh; feeds ucodec_fifo.
`include "assert_macros.svh"

module ucodec_front import ucodec_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input words
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [CHAR_W-1:0]     in_char_i,
  input  logic                  in_end_i,
  // config writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // queue side
  input  logic                  q_full_i,
  output logic                  push_o,
  output op_t                   op_o
);

  logic                  mode_q;
  logic [CFG_DATA_W-1:0] set0_q, set1_q, set2_q, set3_q;
  esc_state_e            esc_q, esc_d;
  logic [3:0]            hi_q, hi_d;

  logic          in_acc;
  logic          cfg_acc;
  logic [255:0]  enc_mask;
  logic [3:0]    nib;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i;
  assign in_ready_o  = !q_full_i;
  assign in_acc      = in_valid_i && in_ready_o;

  assign enc_mask = {set3_q, set2_q, set1_q, set0_q};
  assign nib      = nibble_of(in_char_i);

  // classify the incoming word and track escapes in decode mode
  always_comb begin
    esc_d   = esc_q;
    hi_d    = hi_q;
    push_o  = 1'b0;
    op_o    = '{esc: 1'b0, ch: in_char_i, last: in_end_i, cut: 1'b0};
    if (in_acc) begin
      if (!mode_q) begin
        push_o = 1'b1;
        op_o.esc = enc_mask[in_char_i];
      end else begin
        unique case (esc_q)
          ESC_PCT: begin
            hi_d  = nib;
            esc_d = ESC_DIG;
          end
          ESC_DIG: begin
            push_o  = 1'b1;
            op_o.ch = {hi_q, nib};
            esc_d   = ESC_IDLE;
            hi_d    = 4'd0;
          end
          default: begin
            if (in_char_i == PERCENT_CHAR) begin
              esc_d = ESC_PCT;
            end else begin
              push_o = 1'b1;
              esc_d  = ESC_IDLE;
            end
          end
        endcase
        // string ends inside an escape: one flagged zero byte
        if (in_end_i && (esc_d != ESC_IDLE)) begin
          push_o = 1'b1;
          op_o   = '{esc: 1'b0, ch: '0, last: 1'b1, cut: 1'b1};
          esc_d  = ESC_IDLE;
          hi_d   = 4'd0;
        end
      end
    end
  end

  // state and config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      set0_q <= '0;
      set1_q <= '0;
      set2_q <= '0;
      set3_q <= '0;
      esc_q  <= ESC_IDLE;
      hi_q   <= 4'd0;
    end else if (cfg_acc) begin
      unique case (cfg_index_i)
        REG_DECODE_MODE: begin
          mode_q <= cfg_data_i[0];
          esc_q  <= ESC_IDLE;
          hi_q   <= 4'd0;
        end
        REG_SET_0: set0_q <= cfg_data_i;
        REG_SET_1: set1_q <= cfg_data_i;
        REG_SET_2: set2_q <= cfg_data_i;
        REG_SET_3: set3_q <= cfg_data_i;
        default: ;
      endcase
    end else begin
      esc_q <= esc_d;
      hi_q  <= hi_d;
    end
  end

  // encode mode never leaves the escape tracker busy
  `ASSERT_IMPLY(a_enc_idle, clk_i, rst_ni, !mode_q, esc_q == ESC_IDLE)
  // a cut escape always closes the string
  `ASSERT_IMPLY(a_cut_last, clk_i, rst_ni, push_o && op_o.cut, op_o.last && !op_o.esc)

endmodule

/* hdl/ucodec_fifo.sv */
// Short queue of classified operations between front and back.
// Depends on ucodec_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ucodec_fifo import ucodec_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  op_i,
  output logic full_o,
  input  logic pop_i,
  output op_t  op_o,
  output logic empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  op_t              slot_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign op_o    = slot_q[rd_q];

  // payload slots
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= op_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  `ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, (push_i && full_o) || (pop_i && empty_o))

endmodule

/* hdl/ucodec_back.sv */
// Back end: expands queued operations into output words through an output register.
// Depends on ucodec_pkg and assert_macros.svh; drains ucodec_fifo.
`include "assert_macros.svh"

module ucodec_back import ucodec_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // queue side
  input  logic              q_empty_i,
  input  op_t               op_i,
  output logic              pop_o,
  // output words
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CHAR_W-1:0] out_char_o,
  output logic              out_end_o,
  output logic              cut_escape_o
);

  out_phase_e        ph_q, ph_d;
  logic              vld_q, vld_d;
  logic [CHAR_W-1:0] ch_q, ch_d;
  logic              end_q, end_d;
  logic              cut_q, cut_d;
  logic              load;

  assign load = !vld_q || out_ready_i;

  // pick the next word of the head operation
  always_comb begin
    ph_d  = ph_q;
    vld_d = vld_q && !out_ready_i;
    ch_d  = ch_q;
    end_d = end_q;
    cut_d = cut_q;
    pop_o = 1'b0;
    if (load && !q_empty_i) begin
      vld_d = 1'b1;
      cut_d = op_i.cut;
      if (!op_i.esc) begin
        ch_d  = op_i.ch;
        end_d = op_i.last;
        pop_o = 1'b1;
        ph_d  = PH_FIRST;
      end else begin
        unique case (ph_q)
          PH_FIRST: begin
            ch_d  = PERCENT_CHAR;
            end_d = 1'b0;
            ph_d  = PH_HI;
          end
          PH_HI: begin
            ch_d  = hex_digit(op_i.ch[7:4]);
            end_d = 1'b0;
            ph_d  = PH_LO;
          end
          default: begin
            ch_d  = hex_digit(op_i.ch[3:0]);
            end_d = op_i.last;
            pop_o = 1'b1;
            ph_d  = PH_FIRST;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= PH_FIRST;
      vld_q <= 1'b0;
    end else begin
      ph_q  <= ph_d;
      vld_q <= vld_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    ch_q  <= ch_d;
    end_q <= end_d;
    cut_q <= cut_d;
  end

  assign out_valid_o  = vld_q;
  assign out_char_o   = ch_q;
  assign out_end_o    = end_q;
  assign cut_escape_o = cut_q;

  // mid-expansion the head operation stays queued
  `ASSERT_IMPLY(a_head_held, clk_i, rst_ni, ph_q != PH_FIRST, !q_empty_i && op_i.esc)
  // a word is only dropped from the queue as it enters the output register
  `ASSERT_NEXT(a_pop_loads, clk_i, rst_ni, pop_o, vld_q)

endmodule

/* hdl/url_percent_codec_top.sv */
// Top level of the URL percent codec: front end, operation queue, back end.
// Depends on ucodec_pkg, ucodec_if, ucodec_front, ucodec_fifo, ucodec_back.
//
// Usage:
//   in_ch   valid/ready channel of input bytes (in_char, in_end marks the last).
//   out_ch  valid/ready channel of result bytes (out_char, out_end, cut_escape).
//   cfg_ch  register writes: index 0 decode_mode, 1..4 encode_set_0..3; always
//           ready; write only while no word is in flight.
// Result path: an input byte's operation is written to a queue slot as the byte
// is taken, then loaded into the back end's output register, which drives out_ch.
// Throughput: one output word per cycle while the receiver is ready and the queue
// holds an operation, set by the back end's output register; an encoded byte
// gives three words and any other byte one. Decode-mode bytes that open an
// escape give no word.
// Input is taken whenever the FIFO_DEPTH-entry queue has room, so the front
// keeps accepting while the receiver stalls until the queue fills.
// Reset clears the config and escape registers and empties the queue and output
// register; no word is lost or repeated under any stall pattern.
module url_percent_codec_top import ucodec_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  ucodec_in_if.sink    in_ch,
  ucodec_out_if.source out_ch,
  ucodec_cfg_if.sink   cfg_ch
);

  logic q_full, q_empty, push, pop;
  op_t  push_op, head_op;

  ucodec_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .in_char_i   (in_ch.in_char),
    .in_end_i    (in_ch.in_end),
    .cfg_valid_i (cfg_ch.valid),
    .cfg_ready_o (cfg_ch.ready),
    .cfg_index_i (cfg_ch.index),
    .cfg_data_i  (cfg_ch.data),
    .q_full_i    (q_full),
    .push_o      (push),
    .op_o        (push_op)
  );

  ucodec_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .full_o  (q_full),
    .pop_i   (pop),
    .op_o    (head_op),
    .empty_o (q_empty)
  );

  ucodec_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .op_i         (head_op),
    .pop_o        (pop),
    .out_valid_o  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .out_char_o   (out_ch.out_char),
    .out_end_o    (out_ch.out_end),
    .cut_escape_o (out_ch.cut_escape)
  );

endmodule

/* dv/url_percent_codec_top_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for url_percent_codec_top: directed table, then random phases.
// Depends on ucodec_pkg, the ucodec_*_if interfaces and the url_percent_codec_top RTL.
module url_percent_codec_top_test import ucodec_pkg::*; ();

  localparam int unsigned IDLE_LIMIT      = 2000; // cycles with no handshake at all
  localparam int unsigned SETTLE_CYCLES   = 6;    // pipeline latency plus margin
  localparam int unsigned N_PHASES        = 10;
  localparam int unsigned ITEMS_PER_PHASE = 42;
  localparam int unsigned MAX_REPORTS     = 40;

  // register indexes the block must ignore
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              cut;
  } word_t;

  typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_e;

  // one line of the directed table; n_known > 0 means the words are typed in
  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [CHAR_W-1:0]     ch;
    logic                  last;
    logic [1:0]            n_known;
    word_t [2:0]           known;
  } row_t;

  logic clk;
  logic rst_n;

  ucodec_in_if  in_ch ();
  ucodec_out_if out_ch ();
  ucodec_cfg_if cfg_ch ();

  url_percent_codec_top u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // codec model state
  logic         dec_mode;
  logic [255:0] code_set;
  logic [1:0]   esc_phase;
  logic [3:0]   hi_nib;

  word_t pending_words[$];
  row_t  script[$];

  int unsigned idle_cycles;
  int unsigned mismatches;
  int unsigned words_checked;
  int unsigned cuts_checked;
  int unsigned bytes_sent;
  int unsigned cfg_writes;
  bit          in_quiet;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic word_t word_of(input logic [CHAR_W-1:0] ch, input logic last,
                                    input logic cut);
    word_t w;
    w.ch   = ch;
    w.last = last;
    w.cut  = cut;
    return w;
  endfunction

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return DIGIT_BASE + CHAR_W'(v);
    return CH_UPPER_A + CHAR_W'(v) - 8'd10;
  endfunction

  // escape digit value; anything outside '0'..'9' is taken against 'A' - 10
  function automatic logic [3:0] digit_value(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] off;
    if (c >= DIGIT_BASE && c <= DIGIT_LAST) off = c - DIGIT_BASE;
    else off = c - ALPHA_BASE;
    return off[3:0];
  endfunction

  // mostly short gaps, a few long ones, none during a quiet stretch
  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CHAR_W-1:0] rand_digit();
    logic [3:0] v;
    v = 4'($urandom_range(0, 15));
    if (v < 4'd10) return DIGIT_BASE + CHAR_W'(v);
    return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + CHAR_W'(v) - 8'd10;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] set_pattern();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      4: return 64'h1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // work out the words one input byte gives and queue them
  function automatic void convert_byte(input logic [CHAR_W-1:0] ch, input logic last);
    bit opened;
    opened = 1'b0;
    if (!dec_mode) begin
      if (code_set[ch]) begin
        pending_words.push_back(word_of(PERCENT_CHAR, 1'b0, 1'b0));
        pending_words.push_back(word_of(hex_char(ch[7:4]), 1'b0, 1'b0));
        pending_words.push_back(word_of(hex_char(ch[3:0]), last, 1'b0));
      end else begin
        pending_words.push_back(word_of(ch, last, 1'b0));
      end
      return;
    end
    case (esc_phase)
      2'd1: begin
        hi_nib    = digit_value(ch);
        esc_phase = 2'd2;
        opened    = 1'b1;
      end
      2'd2: begin
        pending_words.push_back(word_of({hi_nib, digit_value(ch)}, last, 1'b0));
        esc_phase = 2'd0;
        hi_nib    = 4'd0;
      end
      default: begin
        if (ch == PERCENT_CHAR) begin
          esc_phase = 2'd1;
          opened    = 1'b1;
        end else begin
          esc_phase = 2'd0;
          pending_words.push_back(word_of(ch, last, 1'b0));
        end
      end
    endcase
    // string ends inside an escape: one flagged zero word
    if (opened && last) begin
      esc_phase = 2'd0;
      hi_nib    = 4'd0;
      pending_words.push_back(word_of(8'h00, 1'b1, 1'b1));
    end
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task automatic check_word();
    word_t want;
    if (pending_words.size() == 0) begin
      flag_mismatch("unexpected word", out_ch.out_char, 0);
    end else begin
      want = pending_words.pop_front();
      if (out_ch.out_char !== want.ch) flag_mismatch("out_char", out_ch.out_char, want.ch);
      if (out_ch.out_end !== want.last) flag_mismatch("out_end", out_ch.out_end, want.last);
      if (out_ch.cut_escape !== want.cut)
        flag_mismatch("cut_escape", out_ch.cut_escape, want.cut);
      words_checked++;
      if (want.cut) cuts_checked++;
    end
  endtask

  // output monitor and activity count for the watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_word();
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver back-pressure
  initial begin
    int stall_left;
    bit out_quiet;
    stall_left = 0;
    out_quiet  = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        if ($urandom_range(0, 49) == 0) out_quiet = !out_quiet;
        stall_left = pick_gap(out_quiet);
        if (stall_left > 0) begin
          out_ch.ready <= 1'b0;
          stall_left--;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    wait (rst_n === 1'b1);
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("[%0t] no handshake for %0d cycles", $time, IDLE_LIMIT);
    $display("url_percent_codec_top verification failed");
    $finish;
  end

  // drop valid and let every expected word come out
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_DECODE_MODE: begin
        dec_mode  = data[0];
        esc_phase = 2'd0;
        hi_nib    = 4'd0;
      end
      REG_SET_0: code_set[63:0]    = data;
      REG_SET_1: code_set[127:64]  = data;
      REG_SET_2: code_set[191:128] = data;
      REG_SET_3: code_set[255:192] = data;
      default: ;
    endcase
    cfg_writes++;
  endtask

  // one input word; typed-in words replace the model's where given
  task automatic send_byte(input logic [CHAR_W-1:0] ch, input logic last,
                           input logic [1:0] n_known, input word_t [2:0] known);
    int gap;
    int mark;
    if ($urandom_range(0, 39) == 0) in_quiet = !in_quiet;
    gap = pick_gap(in_quiet);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_char <= ch;
    in_ch.in_end  <= last;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    mark = pending_words.size();
    convert_byte(ch, last);
    if (n_known != 2'd0) begin
      while (pending_words.size() > mark) void'(pending_words.pop_back());
      for (int i = 0; i < int'(n_known); i++) pending_words.push_back(known[i]);
    end
    bytes_sent++;
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.data = data;
    script.push_back(r);
  endtask

  task automatic add_known(input logic [CHAR_W-1:0] ch, input logic last, input int n,
                           input word_t w0, input word_t w1, input word_t w2);
    row_t r;
    r          = '0;
    r.kind     = ROW_BYTE;
    r.ch       = ch;
    r.last     = last;
    r.n_known  = 2'(n);
    r.known[0] = w0;
    r.known[1] = w1;
    r.known[2] = w2;
    script.push_back(r);
  endtask

  task automatic add_byte(input logic [CHAR_W-1:0] ch, input logic last);
    add_known(ch, last, 0, '0, '0, '0);
  endtask

  // one random token: plain byte, escape, cut escape or noise; returns bytes sent
  task automatic random_token(input logic decode, output int count);
    logic [CHAR_W-1:0] c;
    logic              last;
    int                r;
    last  = ($urandom_range(0, 9) == 0);
    count = 0;
    if (!decode) begin
      send_byte(CHAR_W'($urandom_range(0, 255)), last, 2'd0, '0);
      count = 1;
      return;
    end
    r = $urandom_range(0, 9);
    if (r < 6) begin
      if ($urandom_range(0, 11) == 0) begin
        // string cut inside the escape
        if ($urandom_range(0, 1)) begin
          send_byte(PERCENT_CHAR, 1'b1, 2'd0, '0);
          count = 1;
        end else begin
          send_byte(PERCENT_CHAR, 1'b0, 2'd0, '0);
          send_byte(rand_digit(), 1'b1, 2'd0, '0);
          count = 2;
        end
      end else begin
        send_byte(PERCENT_CHAR, 1'b0, 2'd0, '0);
        send_byte(rand_digit(), 1'b0, 2'd0, '0);
        send_byte(rand_digit(), last, 2'd0, '0);
        count = 3;
      end
    end else if (r < 9) begin
      c = CHAR_W'($urandom_range(0, 255));
      if (c == PERCENT_CHAR) c = c + 8'd1;
      send_byte(c, last, 2'd0, '0);
      count = 1;
    end else begin
      // escape with arbitrary, mostly non-hex, digits
      send_byte(PERCENT_CHAR, 1'b0, 2'd0, '0);
      send_byte(CHAR_W'($urandom_range(0, 255)), 1'b0, 2'd0, '0);
      send_byte(CHAR_W'($urandom_range(0, 255)), last, 2'd0, '0);
      count = 3;
    end
  endtask

  initial begin
    row_t                  r;
    int                    n;
    int                    sent;
    logic                  mode;
    logic [CFG_DATA_W-1:0] mode_word;

    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.in_char  <= '0;
    in_ch.in_end   <= 1'b0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= '0;
    cfg_ch.data    <= '0;
    dec_mode      = 1'b0;
    code_set      = '0;
    esc_phase     = 2'd0;
    hi_nib        = 4'd0;
    mismatches    = 0;
    words_checked = 0;
    cuts_checked  = 0;
    bytes_sent    = 0;
    cfg_writes    = 0;
    in_quiet      = 1'b0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // after reset: encode mode with an empty set, bytes pass untouched
    add_known(8'h00, 1'b0, 1, word_of(8'h00, 1'b0, 1'b0), '0, '0);
    add_known(8'hFF, 1'b1, 1, word_of(8'hFF, 1'b1, 1'b0), '0, '0);
    add_cfg(REG_SET_0, '1);
    add_cfg(REG_SET_3, '1);
    add_cfg(REG_SET_1, 64'h1);
    add_cfg(REG_SET_2, 64'hAAAA_AAAA_AAAA_AAAA);
    // two digits always, also below 16
    add_known(8'h00, 1'b0, 3, word_of(PERCENT_CHAR, 1'b0, 1'b0),
              word_of("0", 1'b0, 1'b0), word_of("0", 1'b0, 1'b0));
    add_known(8'h0A, 1'b1, 3, word_of(PERCENT_CHAR, 1'b0, 1'b0),
              word_of("0", 1'b0, 1'b0), word_of("A", 1'b1, 1'b0));
    add_known(8'hFF, 1'b0, 3, word_of(PERCENT_CHAR, 1'b0, 1'b0),
              word_of("F", 1'b0, 1'b0), word_of("F", 1'b0, 1'b0));
    add_byte(8'h40, 1'b0);
    add_byte(8'h41, 1'b1);
    add_byte(8'h81, 1'b0);
    add_byte(8'h80, 1'b1);
    // decode: well-formed, lowercase and non-hex escapes
    add_cfg(REG_DECODE_MODE, 64'h1);
    add_byte(PERCENT_CHAR, 1'b0);
    add_byte("4", 1'b0);
    add_byte("1", 1'b0);
    add_byte(PERCENT_CHAR, 1'b0);
    add_byte("f", 1'b0);
    add_byte("F", 1'b1);
    add_byte(PERCENT_CHAR, 1'b0);
    add_byte("G", 1'b0);
    add_byte("z", 1'b0);
    // cut escapes: after the percent and after the first digit
    add_known(PERCENT_CHAR, 1'b1, 1, word_of(8'h00, 1'b1, 1'b1), '0, '0);
    add_byte(PERCENT_CHAR, 1'b0);
    add_known("1", 1'b1, 1, word_of(8'h00, 1'b1, 1'b1), '0, '0);
    // zero byte is ordinary data
    add_known(8'h00, 1'b1, 1, word_of(8'h00, 1'b1, 1'b0), '0, '0);
    // writes to unknown indexes change nothing
    add_cfg(REG_UNUSED_LO, 64'h0);
    add_cfg(REG_UNUSED_HI, 64'h0);
    // mode write in the middle of an escape drops it
    add_byte(PERCENT_CHAR, 1'b0);
    add_cfg(REG_DECODE_MODE, 64'h1);
    add_byte("4", 1'b0);
    // only bit 0 of the mode word counts
    add_cfg(REG_DECODE_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
    add_byte(8'hC3, 1'b1);

    foreach (script[i]) begin
      r = script[i];
      if (r.kind == ROW_CFG) write_reg(r.idx, r.data);
      else send_byte(r.ch, r.last, r.n_known, r.known);
    end

    // random phases, alternating mode, fresh sets each time
    for (int p = 0; p < N_PHASES; p++) begin
      mode      = p[0];
      mode_word = {$urandom, $urandom};
      mode_word[0] = mode;
      write_reg(REG_DECODE_MODE, mode_word);
      write_reg(REG_SET_0, (p == 0) ? '0 : (p == 2) ? '1 : set_pattern());
      write_reg(REG_SET_1, (p == 0) ? '0 : (p == 2) ? '1 : set_pattern());
      write_reg(REG_SET_2, (p == 0) ? '0 : (p == 2) ? '1 : set_pattern());
      write_reg(REG_SET_3, (p == 0) ? '0 : (p == 2) ? '1 : set_pattern());
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        random_token(mode, n);
        sent += n;
      end
    end

    settle();
    $display("Sent %0d bytes over %0d register writes and %0d random phases.",
             bytes_sent, cfg_writes, N_PHASES);
    $display("Checked %0d result words, %0d cut escapes, %0d mismatches.",
             words_checked, cuts_checked, mismatches);
    if (mismatches == 0) begin
      $display("url_percent_codec_top verification clean");
    end else begin
      $display("url_percent_codec_top verification failed");
    end
    $finish;
  end

endmodule
